FILE: rtl/mlk_pkg.sv
// ----------------------------------------------------------------------------
// mlk_pkg
// Shared types, constants and the Morse pattern table of the letter keyer.
// ----------------------------------------------------------------------------
package mlk_pkg;

  localparam int unsigned DIT_W  = 24;
  localparam int unsigned DUR_W  = 26;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned SYM_W  = 2;

  localparam logic [DIT_W-1:0]  DIT_RESET   = 24'd1000;
  localparam logic [CHAR_W-1:0] FIRST_CHAR  = 8'd44;   // comma
  localparam logic [CHAR_W-1:0] LAST_CHAR   = 8'd90;   // upper-case Z
  localparam logic [CHAR_W-1:0] LOWER_FIRST = 8'd97;   // lower-case a
  localparam logic [CHAR_W-1:0] LOWER_LAST  = 8'd122;  // lower-case z
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

  // Symbol codes on the segment channel.
  localparam logic [SYM_W-1:0] SYM_GAP  = 2'd0;
  localparam logic [SYM_W-1:0] SYM_DOT  = 2'd1;
  localparam logic [SYM_W-1:0] SYM_DASH = 2'd2;

  // One pattern: symbol count and dash flags, first symbol in bit 0.
  typedef struct packed {
    logic [2:0] len;
    logic [5:0] dash;
  } pattern_t;

  // Request to the shared duration unit.
  typedef struct packed {
    logic             start;
    logic [DIT_W-1:0] dit;
  } dur_req_t;

  // Pattern table indexed by character code minus comma.
  function automatic pattern_t pattern_lookup(input logic [5:0] idx);
    pattern_t p;
    case (idx)
      6'd0:  p = '{3'd6, 6'b110011};  // comma
      6'd1:  p = '{3'd6, 6'b100001};  // minus
      6'd2:  p = '{3'd6, 6'b101010};  // period
      6'd3:  p = '{3'd5, 6'b001001};  // slash
      6'd4:  p = '{3'd5, 6'b011111};  // 0
      6'd5:  p = '{3'd5, 6'b011110};  // 1
      6'd6:  p = '{3'd5, 6'b011100};  // 2
      6'd7:  p = '{3'd5, 6'b011000};  // 3
      6'd8:  p = '{3'd5, 6'b010000};  // 4
      6'd9:  p = '{3'd5, 6'b000000};  // 5
      6'd10: p = '{3'd5, 6'b000001};  // 6
      6'd11: p = '{3'd5, 6'b000011};  // 7
      6'd12: p = '{3'd5, 6'b000111};  // 8
      6'd13: p = '{3'd5, 6'b001111};  // 9
      6'd14: p = '{3'd6, 6'b000111};  // colon
      6'd15: p = '{3'd6, 6'b010101};  // semicolon
      6'd17: p = '{3'd5, 6'b010001};  // equals
      6'd19: p = '{3'd6, 6'b001100};  // question mark
      6'd21: p = '{3'd2, 6'b000010};  // A
      6'd22: p = '{3'd4, 6'b000001};  // B
      6'd23: p = '{3'd4, 6'b000101};  // C
      6'd24: p = '{3'd3, 6'b000001};  // D
      6'd25: p = '{3'd1, 6'b000000};  // E
      6'd26: p = '{3'd4, 6'b000100};  // F
      6'd27: p = '{3'd3, 6'b000011};  // G
      6'd28: p = '{3'd4, 6'b000000};  // H
      6'd29: p = '{3'd2, 6'b000000};  // I
      6'd30: p = '{3'd4, 6'b001110};  // J
      6'd31: p = '{3'd3, 6'b000101};  // K
      6'd32: p = '{3'd4, 6'b000010};  // L
      6'd33: p = '{3'd2, 6'b000011};  // M
      6'd34: p = '{3'd2, 6'b000001};  // N
      6'd35: p = '{3'd3, 6'b000111};  // O
      6'd36: p = '{3'd4, 6'b000110};  // P
      6'd37: p = '{3'd4, 6'b001011};  // Q
      6'd38: p = '{3'd3, 6'b000010};  // R
      6'd39: p = '{3'd3, 6'b000000};  // S
      6'd40: p = '{3'd1, 6'b000001};  // T
      6'd41: p = '{3'd3, 6'b000100};  // U
      6'd42: p = '{3'd4, 6'b001000};  // V
      6'd43: p = '{3'd3, 6'b000110};  // W
      6'd44: p = '{3'd4, 6'b001001};  // X
      6'd45: p = '{3'd4, 6'b001101};  // Y
      6'd46: p = '{3'd4, 6'b000011};  // Z
      // Less-than, greater-than, at sign and unused codes have no symbols.
      default: p = '{3'd0, 6'b000000};
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/mlk_if.sv
// ----------------------------------------------------------------------------
// mlk_if
// Valid/ready channels of the letter keyer: characters, segments, config.
// ----------------------------------------------------------------------------
interface mlk_char_if import mlk_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface mlk_seg_if import mlk_pkg::*;;
  logic             valid;
  logic             ready;
  logic             key_on;
  logic [SYM_W-1:0] symbol;
  logic [DUR_W-1:0] duration;
  logic             last;

  modport source (output valid, output key_on, output symbol, output duration,
                  output last, input ready);
  modport sink   (input valid, input key_on, input symbol, input duration,
                  input last, output ready);
endinterface

interface mlk_cfg_if import mlk_pkg::*;;
  logic             valid;
  logic             ready;
  logic [DIT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/mlk_dur.sv
// ----------------------------------------------------------------------------
// mlk_dur
// Shared duration adder: forms three dit lengths as dit plus twice dit.
// ----------------------------------------------------------------------------
module mlk_dur import mlk_pkg::*; (
  input  logic             clk,
  input  dur_req_t         req,
  output logic [DUR_W-1:0] triple
);

  // The sum is captured once per character and held for all dashes and the closing pause.
  always_ff @(posedge clk) begin
    if (req.start) begin
      triple <= {2'b00, req.dit} + {1'b0, req.dit, 1'b0};
    end
  end

endmodule

FILE: rtl/mlk_seq.sv
// ----------------------------------------------------------------------------
// mlk_seq
// Character decode and segment sequencer with the segment output register.
// ----------------------------------------------------------------------------
module mlk_seq import mlk_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  mlk_char_if.sink         char_in,
  mlk_seg_if.source        seg_out,
  input  logic [DIT_W-1:0] dit,
  output dur_req_t         dur_req,
  input  logic [DUR_W-1:0] triple
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOAD = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t           state;
  logic [2:0]       remain;
  logic [5:0]       dash_bits;
  logic             in_gap;
  logic             seg_valid;

  logic [CHAR_W-1:0] folded;
  logic              in_range;
  logic [CHAR_W-1:0] offset;
  pattern_t          pat;
  logic              advance;

  logic             cur_key_on;
  logic [SYM_W-1:0] cur_symbol;
  logic [DUR_W-1:0] cur_duration;
  logic             cur_last;
  logic [DUR_W-1:0] one;

  // Fold lower case and look up the pattern of the incoming character.
  always_comb begin
    if (char_in.char_code >= LOWER_FIRST && char_in.char_code <= LOWER_LAST) begin
      folded = char_in.char_code - CASE_OFFSET;
    end else begin
      folded = char_in.char_code;
    end
    in_range = (folded >= FIRST_CHAR) && (folded <= LAST_CHAR);
    offset   = folded - FIRST_CHAR;
    pat      = pattern_lookup(offset[5:0]);
  end

  assign char_in.ready = (state == S_IDLE);
  assign dur_req.start = (state == S_LOAD);
  assign dur_req.dit   = dit;
  assign one           = {2'b00, dit};

  // The segment that goes out next: symbol, gap after it, or closing pause.
  always_comb begin
    if (in_gap) begin
      cur_key_on   = 1'b0;
      cur_symbol   = SYM_GAP;
      cur_duration = one;
      cur_last     = 1'b0;
    end else if (remain != 3'd0) begin
      cur_key_on   = 1'b1;
      cur_symbol   = dash_bits[0] ? SYM_DASH : SYM_DOT;
      cur_duration = dash_bits[0] ? triple : one;
      cur_last     = 1'b0;
    end else begin
      cur_key_on   = 1'b0;
      cur_symbol   = SYM_GAP;
      cur_duration = triple;
      cur_last     = 1'b1;
    end
  end

  assign advance = (state == S_EMIT) && (!seg_valid || seg_out.ready);

  // Sequencer and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_valid <= 1'b0;
      in_gap    <= 1'b0;
    end else begin
      if (seg_valid && seg_out.ready) begin
        seg_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (char_in.valid && in_range) begin
            remain    <= pat.len;
            dash_bits <= pat.dash;
            in_gap    <= 1'b0;
            state     <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (advance) begin
            seg_valid <= 1'b1;
            if (in_gap) begin
              in_gap    <= 1'b0;
              remain    <= remain - 3'd1;
              dash_bits <= {1'b0, dash_bits[5:1]};
            end else if (remain != 3'd0) begin
              in_gap <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Segment payload register.
  always_ff @(posedge clk) begin
    if (advance) begin
      seg_out.key_on   <= cur_key_on;
      seg_out.symbol   <= cur_symbol;
      seg_out.duration <= cur_duration;
      seg_out.last     <= cur_last;
    end
  end

  assign seg_out.valid = seg_valid;

endmodule

FILE: rtl/morse_letter_keyer_unit.sv
// ----------------------------------------------------------------------------
// morse_letter_keyer_unit
// Turns one ASCII character into the timed key segments of its Morse code.
// ----------------------------------------------------------------------------
// A character outside the comma to Z range (after folding lower case) is
// dropped at once. A character that is taken passes through the load state,
// where the shared adder forms the three-dit length, and then emits its
// segments, one per cycle while the sink takes them: 2*n+1 segments for n dots
// and dashes. The next character is taken only once the closing pause is issued.
// The user must write the dit length on the config channel only while no
// character is in flight; the block itself does not enforce this. The dit
// length resets to 1000 ticks.
module morse_letter_keyer_unit import mlk_pkg::*; (
  input logic       clk,
  input logic       rst,
  mlk_char_if.sink  char_in,
  mlk_seg_if.source seg_out,
  mlk_cfg_if.sink   cfg
);

  logic [DIT_W-1:0] dit;
  logic [DUR_W-1:0] triple;
  dur_req_t         dur_req;

  // Dit length register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dit <= DIT_RESET;
    end else if (cfg.valid) begin
      dit <= cfg.data;
    end
  end

  mlk_dur u_dur (
    .clk    (clk),
    .req    (dur_req),
    .triple (triple)
  );

  mlk_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_in),
    .seg_out (seg_out),
    .dit     (dit),
    .dur_req (dur_req),
    .triple  (triple)
  );

endmodule

FILE: rtl/mlk_checker.sv
// ----------------------------------------------------------------------------
// mlk_checker
// Port-level checks of the letter keyer, bound to the top level.
// ----------------------------------------------------------------------------
module mlk_checker import mlk_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             seg_valid,
  input logic             seg_ready,
  input logic             seg_key_on,
  input logic [SYM_W-1:0] seg_symbol,
  input logic [DUR_W-1:0] seg_duration,
  input logic             seg_last
);

  // A stalled segment request keeps its payload.
  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_ready |=> seg_valid && $stable(seg_symbol)
      && $stable(seg_duration) && $stable(seg_last) && $stable(seg_key_on))
    else $error("segment changed while stalled");

  // The key is on exactly for dots and dashes.
  a_key_sym: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> (seg_key_on == (seg_symbol != SYM_GAP))
      && (seg_symbol == SYM_GAP || seg_symbol == SYM_DOT || seg_symbol == SYM_DASH))
    else $error("key state does not match symbol");

  // The closing pause is a key-off gap.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_last |-> !seg_key_on && (seg_symbol == SYM_GAP))
    else $error("closing pause is not a gap");

  // No new character is taken while a character is still being sent.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg_last |-> !in_ready)
    else $error("input ready in the middle of a character");

endmodule

bind morse_letter_keyer_unit mlk_checker u_mlk_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (char_in.ready),
  .seg_valid    (seg_out.valid),
  .seg_ready    (seg_out.ready),
  .seg_key_on   (seg_out.key_on),
  .seg_symbol   (seg_out.symbol),
  .seg_duration (seg_out.duration),
  .seg_last     (seg_out.last)
);

FILE: dv/tb_morse_letter_keyer_unit.sv
// ----------------------------------------------------------------------------
// tb_morse_letter_keyer_unit
// Self-checking bench for the Morse letter keyer: characters in, key segments out.
// ----------------------------------------------------------------------------
// A queue of characters feeds a clocked driver. A clocked monitor predicts the
// segments of every accepted character and checks each segment as it is taken.
// The dit length is changed between phases, and the extremes are included.
// Both handshake sides idle at random. Once, the segment sink holds off for a
// long stretch so that the keyer stalls its character input.
// ----------------------------------------------------------------------------
module tb_morse_letter_keyer_unit;
  import mlk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEMS_PER_PHASE = 72;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned HOLD_CYCLES     = 300;

  // One expected key segment.
  typedef struct packed {
    logic             key_on;
    logic [SYM_W-1:0] symbol;
    logic [DUR_W-1:0] duration;
    logic             last;
  } key_seg_t;

  // Dot and dash strings for the characters from comma to upper-case Z.
  string morse_code_tab [47] = '{
    "--..--", "-....-", ".-.-.-", "-..-.",
    "-----", ".----", "..---", "...--", "....-",
    ".....", "-....", "--...", "---..", "----.",
    "---...", "-.-.-.", "", "-...-", "", "..--..", "",
    ".-", "-...", "-.-.", "-..", ".", "..-.", "--.",
    "....", "..", ".---", "-.-", ".-..", "--", "-.",
    "---", ".--.", "--.-", ".-.", "...", "-", "..-",
    "...-", ".--", "-..-", "-.--", "--.."
  };

  logic [CHAR_W-1:0] directed_chars [25] = '{
    8'd0, 8'd255, 8'd128, 8'd43, 8'd44, 8'd90, 8'd91, 8'd96, 8'd97,
    8'd122, 8'd123, "<", ">", "@", "-", ".", "/", "0", "9", "?", ";",
    ":", "=", "E", "t"
  };

  logic clk;
  logic rst;

  mlk_char_if char_bus ();
  mlk_seg_if  seg_bus ();
  mlk_cfg_if  cfg_bus ();

  morse_letter_keyer_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .char_in (char_bus),
    .seg_out (seg_bus),
    .cfg     (cfg_bus)
  );

  logic [CHAR_W-1:0] chars_pending [$];
  key_seg_t          segs_due [$];
  key_seg_t          seg_want;
  logic [DIT_W-1:0]  dit_now;
  int unsigned       chars_queued;
  int unsigned       chars_taken;
  int unsigned       err_count;
  int unsigned       snd_idle_pct;
  int unsigned       rcv_idle_pct;
  bit                char_took;
  bit                hold_req;
  bit                hold_on;

  // Clock with a 4 ns period.
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Bench timeout.
  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
    if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
      return c - CASE_OFFSET;
    end
    return c;
  endfunction

  // True when the character produces segments at all.
  function automatic bit is_keyed(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] f;
    f = fold_case(c);
    return (f >= FIRST_CHAR && f <= LAST_CHAR);
  endfunction

  // Work out the segments of one character at the current dit length.
  task automatic push_morse_segments(input logic [CHAR_W-1:0] code);
    string            pat;
    logic [DUR_W-1:0] one_dur;
    logic [DUR_W-1:0] three_dur;
    key_seg_t         s;
    int               i;
    if (!is_keyed(code)) begin
      return;
    end
    pat       = morse_code_tab[fold_case(code) - FIRST_CHAR];
    one_dur   = DUR_W'(dit_now);
    three_dur = one_dur * DUR_W'(3);
    for (i = 0; i < pat.len() && i < 6; i++) begin
      s.key_on   = 1'b1;
      s.symbol   = (pat[i] == "-") ? SYM_DASH : SYM_DOT;
      s.duration = (pat[i] == "-") ? three_dur : one_dur;
      s.last     = 1'b0;
      segs_due.push_back(s);
      s = '{1'b0, SYM_GAP, one_dur, 1'b0};
      segs_due.push_back(s);
    end
    s = '{1'b0, SYM_GAP, three_dur, 1'b1};
    segs_due.push_back(s);
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  // Character driver: hold a request until it is taken, then offer the next.
  always @(negedge clk) begin
    if (!char_bus.valid || char_took) begin
      if (chars_pending.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        char_bus.valid     <= 1'b1;
        char_bus.char_code <= chars_pending.pop_front();
      end else begin
        char_bus.valid <= 1'b0;
      end
    end
  end

  // Segment sink: random backpressure plus the long hold-off.
  always @(negedge clk) begin
    seg_bus.ready <= !hold_on && ($urandom_range(99) >= rcv_idle_pct);
  end

  // Long receiver hold-off, counted in cycles once requested.
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Monitor: check taken segments, then predict for a taken character.
  always @(posedge clk) begin
    char_took <= char_bus.valid && char_bus.ready;
    if (!rst) begin
      if (seg_bus.valid && seg_bus.ready) begin
        if (segs_due.size() == 0) begin
          report_mismatch($sformatf(
            "segment with none due: key_on %0d symbol %0d dur %0d last %0d",
            seg_bus.key_on, seg_bus.symbol, seg_bus.duration, seg_bus.last));
        end else begin
          seg_want = segs_due.pop_front();
          if (seg_bus.key_on !== seg_want.key_on) begin
            report_mismatch($sformatf("key_on %0d, want %0d",
                                      seg_bus.key_on, seg_want.key_on));
          end
          if (seg_bus.symbol !== seg_want.symbol) begin
            report_mismatch($sformatf("symbol %0d, want %0d",
                                      seg_bus.symbol, seg_want.symbol));
          end
          if (seg_bus.duration !== seg_want.duration) begin
            report_mismatch($sformatf("duration %0d, want %0d",
                                      seg_bus.duration, seg_want.duration));
          end
          if (seg_bus.last !== seg_want.last) begin
            report_mismatch($sformatf("last %0d, want %0d", seg_bus.last, seg_want.last));
          end
        end
      end
      if (char_bus.valid && char_bus.ready) begin
        push_morse_segments(char_bus.char_code);
        chars_taken++;
      end
    end
  end

  task automatic queue_char(input logic [CHAR_W-1:0] c);
    chars_pending.push_back(c);
    chars_queued++;
  endtask

  // Random character, weighted toward ones that produce segments.
  function automatic logic [CHAR_W-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) begin
      return CHAR_W'($urandom_range(255));
    end else if (r < 55) begin
      return CHAR_W'($urandom_range(90, 65));
    end else if (r < 75) begin
      return CHAR_W'($urandom_range(122, 97));
    end
    return CHAR_W'($urandom_range(90, 44));
  endfunction

  // Wait until every request is taken and every segment has arrived.
  task automatic wait_idle();
    while (chars_taken != chars_queued || segs_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Dit length write on the config channel; only called while idle.
  task automatic write_dit(input logic [DIT_W-1:0] v);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do begin
      @(posedge clk);
    end while (cfg_bus.ready !== 1'b1);
    dit_now = v;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Main sequence: reset, directed characters, then random phases.
  initial begin
    logic [DIT_W-1:0]  dit_plan [6];
    logic [CHAR_W-1:0] c;
    int unsigned       n;
    rst                = 1'b1;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.data       = '0;
    dit_now            = DIT_RESET;
    snd_idle_pct       = 21;
    rcv_idle_pct       = 52;
    dit_plan = '{24'd1, 24'hFFFFFF, 24'd0, DIT_W'($urandom_range(24'hFFFFFF)), 24'd3,
                 DIT_W'($urandom_range(24'hFFFFFF))};
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    foreach (directed_chars[k]) begin
      queue_char(directed_chars[k]);
    end
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        snd_idle_pct = 21;
        rcv_idle_pct = 52;
      end else if (ph < 4) begin
        snd_idle_pct = 52;
        rcv_idle_pct = 21;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      write_dit(dit_plan[ph]);
      if (ph == 4) begin
        hold_req = 1'b1;
      end
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        c = pick_char();
        queue_char(c);
        if (is_keyed(c)) begin
          n++;
        end
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/mlk_pkg.sv
rtl/mlk_if.sv
rtl/mlk_dur.sv
rtl/mlk_seq.sv
rtl/morse_letter_keyer_unit.sv
rtl/mlk_checker.sv
dv/tb_morse_letter_keyer_unit.sv
